[rtl/dbad_pkg.sv]
// ----------------------------------------------------------------------------
// dbad_pkg
// Shared types and constants of the depth block average downsampler.
// ----------------------------------------------------------------------------
package dbad_pkg;

  // frame and block limits
  localparam int MAX_ROW_POINTS = 1024;
  localparam int MAX_FACTOR     = 16;
  localparam int ROW_LIMIT      = 4096;

  // field and register widths
  localparam int COORD_W     = 32;
  localparam int SUM_W       = 40;
  localparam int SLOT_W      = $clog2(MAX_ROW_POINTS);
  localparam int COL_W       = $clog2(MAX_ROW_POINTS);
  localparam int ROW_W       = $clog2(ROW_LIMIT);
  localparam int FACTOR_W    = 5;
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 13;
  localparam int PHASE_W     = $clog2(MAX_FACTOR);
  localparam int DIVISOR_W   = 9;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 13;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_BLOCK_FACTOR = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 2'd2;

  // configuration reset values
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 5'd2;
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic signed [COORD_W-1:0] out_z;
    logic                      frame_last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic accum;
    logic load_out;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic active;
    logic emit;
    logic div_busy;
    logic out_free;
  } status_t;

endpackage

[rtl/dbad_div.sv]
// ----------------------------------------------------------------------------
// dbad_div
// Restoring divider, one quotient bit per cycle, for block sum magnitudes.
// ----------------------------------------------------------------------------
module dbad_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [dbad_pkg::SUM_W-1:0]     dividend,
  input  logic [dbad_pkg::DIVISOR_W-1:0] divisor,
  output logic                           busy,
  output logic [dbad_pkg::COORD_W-1:0]   quotient
);
  import dbad_pkg::*;

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic [CNT_W-1:0]     count;
  logic [SUM_W-1:0]     quo;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W:0]   rem_shift;
  logic [DIVISOR_W:0]   rem_trial;
  logic                 bit_set;

  // one trial subtraction per cycle
  assign rem_shift = {rem, quo[SUM_W-1]};
  assign rem_trial = rem_shift - {1'b0, divisor};
  assign bit_set   = (rem_shift >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(SUM_W);
    end else if (busy) begin
      count <= count - CNT_W'(1);
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // quotient and remainder shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (busy) begin
      quo <= {quo[SUM_W-2:0], bit_set};
      rem <= bit_set ? rem_trial[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
    end
  end

  assign quotient = quo[COORD_W-1:0];

endmodule

[rtl/dbad_datapath.sv]
// ----------------------------------------------------------------------------
// dbad_datapath
// Raster position, per block column sum memory, divider and output register.
// ----------------------------------------------------------------------------
module dbad_datapath (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dbad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dbad_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  dbad_pkg::point_t                 in_point,
  input  dbad_pkg::cmd_t                   cmd,
  output dbad_pkg::status_t                status,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dbad_pkg::result_t                out_result
);
  import dbad_pkg::*;

  typedef struct packed {
    logic signed [SUM_W-1:0]   sum;
    logic signed [COORD_W-1:0] corner_x;
    logic signed [COORD_W-1:0] corner_y;
  } entry_t;

  // configuration registers
  logic [FACTOR_W-1:0] factor_reg;
  logic [WIDTH_W-1:0]  width_reg;
  logic [HEIGHT_W-1:0] height_reg;
  logic                cfg_hit;

  // effective (clamped) settings
  logic [FACTOR_W-1:0]  factor_eff;
  logic [WIDTH_W-1:0]   width_eff;
  logic [HEIGHT_W-1:0]  height_eff;
  logic [FACTOR_W-1:0]  phase_last;
  logic [DIVISOR_W-1:0] divisor;

  // raster position
  logic [COL_W-1:0]   col;
  logic [COL_W-1:0]   col_base;
  logic [SLOT_W-1:0]  block_col;
  logic [PHASE_W-1:0] col_phase;
  logic [ROW_W-1:0]   row;
  logic [ROW_W-1:0]   row_base;
  logic [PHASE_W-1:0] row_phase;

  logic [WIDTH_W-1:0]  col_end;
  logic [HEIGHT_W-1:0] row_end;
  logic                col_wrap;
  logic                row_wrap;
  logic                col_phase_end;
  logic                row_phase_end;
  logic                pos_active;
  logic                pos_first;
  logic                pos_emit;
  logic                pos_last;

  // captured point
  point_t            point_q;
  logic [SLOT_W-1:0] slot_q;
  logic              first_q;
  logic              emit_q;
  logic              last_q;

  // memory and accumulate
  entry_t                  mem [MAX_ROW_POINTS];
  entry_t                  rd_q;
  entry_t                  entry_new;
  logic signed [SUM_W-1:0] z_ext;
  logic                    div_start;
  logic [SUM_W-1:0]        dividend;
  logic                    div_busy;
  logic [COORD_W-1:0]      quotient;
  logic                    sign_q;
  logic [COORD_W-1:0]      corner_x_q;
  logic [COORD_W-1:0]      corner_y_q;

  // clamp settings into their legal ranges
  always_comb begin
    if (factor_reg == '0) begin
      factor_eff = FACTOR_W'(1);
    end else if (factor_reg > FACTOR_W'(MAX_FACTOR)) begin
      factor_eff = FACTOR_W'(MAX_FACTOR);
    end else begin
      factor_eff = factor_reg;
    end
    if (width_reg == '0) begin
      width_eff = WIDTH_W'(1);
    end else if (width_reg > WIDTH_W'(MAX_ROW_POINTS)) begin
      width_eff = WIDTH_W'(MAX_ROW_POINTS);
    end else begin
      width_eff = width_reg;
    end
    if (height_reg == '0) begin
      height_eff = HEIGHT_W'(1);
    end else if (height_reg > HEIGHT_W'(ROW_LIMIT)) begin
      height_eff = HEIGHT_W'(ROW_LIMIT);
    end else begin
      height_eff = height_reg;
    end
  end

  assign phase_last = factor_eff - FACTOR_W'(1);
  assign divisor    = DIVISOR_W'(factor_eff) * DIVISOR_W'(factor_eff);

  // configuration writes restart the frame
  assign cfg_hit = cfg_we && ((cfg_index == CFG_BLOCK_FACTOR) ||
                              (cfg_index == CFG_FRAME_WIDTH)  ||
                              (cfg_index == CFG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      factor_reg <= FACTOR_RESET;
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BLOCK_FACTOR: factor_reg <= cfg_data[FACTOR_W-1:0];
        CFG_FRAME_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
        CFG_FRAME_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // block membership of the current position
  assign col_end       = WIDTH_W'(col_base) + WIDTH_W'(factor_eff);
  assign row_end       = HEIGHT_W'(row_base) + HEIGHT_W'(factor_eff);
  assign col_wrap      = (WIDTH_W'(col) + WIDTH_W'(1)) >= width_eff;
  assign row_wrap      = (HEIGHT_W'(row) + HEIGHT_W'(1)) >= height_eff;
  assign col_phase_end = ({1'b0, col_phase} == phase_last);
  assign row_phase_end = ({1'b0, row_phase} == phase_last);
  assign pos_active    = (col_end <= width_eff) && (row_end <= height_eff);
  assign pos_first     = (col_phase == '0) && (row_phase == '0);
  assign pos_emit      = col_phase_end && row_phase_end;
  assign pos_last      = ((col_end + WIDTH_W'(factor_eff)) > width_eff) &&
                         ((row_end + HEIGHT_W'(factor_eff)) > height_eff);

  // raster position counters
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col       <= '0;
      col_base  <= '0;
      block_col <= '0;
      col_phase <= '0;
      row       <= '0;
      row_base  <= '0;
      row_phase <= '0;
    end else if (cmd.accept) begin
      if (col_wrap) begin
        col       <= '0;
        col_base  <= '0;
        block_col <= '0;
        col_phase <= '0;
        if (row_wrap) begin
          row       <= '0;
          row_base  <= '0;
          row_phase <= '0;
        end else if (row_phase_end) begin
          row       <= row + ROW_W'(1);
          row_base  <= row_base + ROW_W'(factor_eff);
          row_phase <= '0;
        end else begin
          row       <= row + ROW_W'(1);
          row_phase <= row_phase + PHASE_W'(1);
        end
      end else if (col_phase_end) begin
        col       <= col + COL_W'(1);
        col_base  <= col_base + COL_W'(factor_eff);
        block_col <= block_col + SLOT_W'(1);
        col_phase <= '0;
      end else begin
        col       <= col + COL_W'(1);
        col_phase <= col_phase + PHASE_W'(1);
      end
    end
  end

  // capture the accepted point and its block role
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      point_q <= in_point;
      slot_q  <= block_col;
      first_q <= pos_first;
      emit_q  <= pos_emit;
      last_q  <= pos_last;
    end
  end

  // read-modify-write of the block column entry
  assign z_ext = SUM_W'(point_q.point_z);

  always_comb begin
    if (first_q) begin
      entry_new.sum      = z_ext;
      entry_new.corner_x = point_q.point_x;
      entry_new.corner_y = point_q.point_y;
    end else begin
      entry_new.sum      = rd_q.sum + z_ext;
      entry_new.corner_x = rd_q.corner_x;
      entry_new.corner_y = rd_q.corner_y;
    end
  end

  always_ff @(posedge clk) begin
    rd_q <= mem[slot_q];
    if (cmd.accum) begin
      mem[slot_q] <= entry_new;
    end
  end

  // divide the block sum magnitude, sign restored at the output
  assign div_start = cmd.accum && emit_q;
  assign dividend  = entry_new.sum[SUM_W-1] ? SUM_W'(-entry_new.sum) : SUM_W'(entry_new.sum);

  always_ff @(posedge clk) begin
    if (div_start) begin
      sign_q     <= entry_new.sum[SUM_W-1];
      corner_x_q <= entry_new.corner_x;
      corner_y_q <= entry_new.corner_y;
    end
  end

  dbad_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_result.out_x      <= corner_x_q;
      out_result.out_y      <= corner_y_q;
      out_result.out_z      <= sign_q ? (COORD_W'(0) - quotient) : quotient;
      out_result.frame_last <= last_q;
    end
  end

  assign status.active   = pos_active;
  assign status.emit     = emit_q;
  assign status.div_busy = div_busy;
  assign status.out_free = !out_valid || out_ready;

endmodule

[rtl/dbad_ctrl.sv]
// ----------------------------------------------------------------------------
// dbad_ctrl
// Sequencer for point capture, accumulate, divide and result hand-off.
// ----------------------------------------------------------------------------
module dbad_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dbad_pkg::status_t status,
  output dbad_pkg::cmd_t    cmd
);
  import dbad_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_ACCUM,
    S_DIVIDE
  } state_t;

  state_t state;

  // command decode
  assign in_ready     = (state == S_IDLE);
  assign cmd.accept   = in_valid && in_ready;
  assign cmd.accum    = (state == S_ACCUM);
  assign cmd.load_out = (state == S_DIVIDE) && !status.div_busy && status.out_free;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.accept && status.active) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_ACCUM;
        end
        S_ACCUM: begin
          state <= status.emit ? S_DIVIDE : S_IDLE;
        end
        S_DIVIDE: begin
          if (cmd.load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/depth_block_average_downsampler_top.sv]
// Sequencing: a point outside any full block is accepted back to back; a point
// inside a block holds the input through capture, memory read and accumulate.
// A block's bottom-right point also waits for the bit-serial divider, whose result
// is loaded into the output register before the next point is accepted.
// Stalls: a block result waits until the output register is free, holding the input.
// Reset: synchronous, restores factor 2, width 640, height 480, frame start.
// ----------------------------------------------------------------------------
// depth_block_average_downsampler_top
// Block-average downsampler of an organized depth cloud streamed in raster order.
// ----------------------------------------------------------------------------
module depth_block_average_downsampler_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dbad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [dbad_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  dbad_pkg::point_t                 in_point,
  output logic                             out_valid,
  input  logic                             out_ready,
  output dbad_pkg::result_t                out_result
);
  import dbad_pkg::*;

  cmd_t    cmd;
  status_t status;

  // controller
  dbad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  dbad_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_point   (in_point),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_result (out_result)
  );

endmodule
